// File: hdl/wav_header_parse_and_unpack_defines.svh
`ifndef WAV_HEADER_PARSE_AND_UNPACK_DEFINES_SVH
`define WAV_HEADER_PARSE_AND_UNPACK_DEFINES_SVH
// Assertion helpers, clocked on clk and disabled during rst.
`define WAVP_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wavp check failed");
`define WAVP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wavp check failed");
`endif

// File: hdl/wavp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wavp_pkg;
  typedef enum logic [3:0] {
    PH_MAGIC, PH_HDR_FMT, PH_SKIP_FMT, PH_FMT_BODY,
    PH_HDR_DATA, PH_SKIP_DATA, PH_SAMPLES, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    CS_RUN, CS_SAMP_GO, CS_SAMP_WAIT, CS_FRM_GO, CS_FRM_WAIT, CS_HDR
  } ctrl_state_t;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_SMP = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HDR  = 3'd1;
  localparam logic [2:0] ST_FMT_SIZE = 3'd2;
  localparam logic [2:0] ST_NOT_PCM  = 3'd3;
  localparam logic [2:0] ST_NO_CH    = 3'd4;
  localparam logic [2:0] ST_NO_SIZE  = 3'd5;
  localparam logic [2:0] ST_NO_DATA  = 3'd6;

  localparam logic [1:0] REG_RAW_MODE  = 2'd0;
  localparam logic [1:0] REG_RAW_BYTES = 2'd1;

  localparam logic [31:0] ID_RIFF   = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE   = 32'h4556_4157;
  localparam logic [31:0] ID_FMT    = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA   = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;
  localparam logic [5:0]  FMT_MAX   = 6'd40;
  localparam logic [31:0] RAW_LIMIT = 32'h7fff_ffff;

  typedef struct packed {
    logic step;
    logic div_start;
    logic div_frames;
    logic store_total;
    logic load_step;
    logic load_hdr;
  } dp_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic need_div;
    logic div_busy;
  } dp_sts_t;
endpackage
`default_nettype wire

// File: hdl/wavp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface wavp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink (input valid, data_byte, stream_end, output ready);
endinterface

interface wavp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         status;
  logic [15:0]        channels;
  logic [31:0]        sample_rate;
  logic [13:0]        bytes_per_sample;
  logic [31:0]        channel_mask;
  logic [31:0]        sample_count;
  logic [31:0]        frame_count;
  logic signed [31:0] sample_value;
  modport source (output valid, kind, status, channels, sample_rate, bytes_per_sample,
    channel_mask, sample_count, frame_count, sample_value, input ready);
  modport sink (input valid, kind, status, channels, sample_rate, bytes_per_sample,
    channel_mask, sample_count, frame_count, sample_value, output ready);
endinterface

interface wavp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/wav_header_parse_and_unpack.sv
// One byte request per cycle while the result register is free; a sample or
// error result is registered and shows in the cycle after its byte. The byte that
// ends the data chunk header starts two shared 32-step divisions (sample and
// frame counts); input is held off until the header result is loaded.
// Synchronous active-high rst returns the parser to RIFF detection and the
// registers to raw_mode 0, raw_sample_bytes 2.
`timescale 1ns / 1ps
`default_nettype none
module wav_header_parse_and_unpack (
  input  wire logic   clk,
  input  wire logic   rst,
  wavp_byte_if.sink   src,
  wavp_res_if.source  res,
  wavp_cfg_if.sink    cfg
);
  wavp_pkg::dp_cmd_t cmd;
  wavp_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  wavp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (src.valid),
    .in_ready  (src.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wavp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .data_byte        (src.data_byte),
    .stream_end       (src.stream_end),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .kind             (res.kind),
    .status           (res.status),
    .channels         (res.channels),
    .sample_rate      (res.sample_rate),
    .bytes_per_sample (res.bytes_per_sample),
    .channel_mask     (res.channel_mask),
    .sample_count     (res.sample_count),
    .frame_count      (res.frame_count),
    .sample_value     (res.sample_value)
  );
endmodule
`default_nettype wire

// File: hdl/wavp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// 32-bit restoring divider, one quotient bit per cycle
module wavp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem, quotient[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'd32;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/wavp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module wavp_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wavp_pkg::dp_cmd_t cmd,
  output wavp_pkg::dp_sts_t   sts,
  input  wire logic [7:0]     data_byte,
  input  wire logic           stream_end,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data,
  output logic [1:0]          kind,
  output logic [2:0]          status,
  output logic [15:0]         channels,
  output logic [31:0]         sample_rate,
  output logic [13:0]         bytes_per_sample,
  output logic [31:0]         channel_mask,
  output logic [31:0]         sample_count,
  output logic [31:0]         frame_count,
  output logic signed [31:0]  sample_value
);
  logic raw_mode;
  logic [2:0] raw_sample_bytes;

  wavp_pkg::phase_t phase, phase_next;
  logic [5:0]  fbi, fbi_next;
  logic [31:0] chunk, chunk_next;
  logic [31:0] word, word_next;
  logic [5:0]  fmt_size, fmt_size_next;
  logic [15:0] fmt_code, fmt_code_next;
  logic [15:0] sub_fmt, sub_fmt_next;
  logic [15:0] ch, ch_next;
  logic [31:0] rate, rate_next;
  logic [13:0] sbytes, sbytes_next;
  logic [31:0] mask, mask_next;
  logic [31:0] total, total_next;
  logic [31:0] emitted, emitted_next;
  logic [31:0] sasm, sasm_next;
  logic [1:0]  bis, bis_next;

  logic        emit, need_div, do_take, do_finish;
  logic [1:0]  e_kind;
  logic [2:0]  e_status;
  logic [31:0] e_value;
  logic [16:0] bits_sum;

  logic        div_busy;
  logic [31:0] quot;

  wavp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_frames ? total : chunk),
    .divisor  (cmd.div_frames ? {16'b0, ch} : {18'b0, sbytes}),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign sts.res_valid = emit;
  assign sts.need_div  = need_div;
  assign sts.div_busy  = div_busy;

  assign bits_sum = {1'b0, word_next[15:0]} + 17'd7;

  // parse step for one byte
  always_comb begin
    phase_next = phase; fbi_next = fbi; chunk_next = chunk; word_next = word;
    fmt_size_next = fmt_size; fmt_code_next = fmt_code; sub_fmt_next = sub_fmt;
    ch_next = ch; rate_next = rate; sbytes_next = sbytes; mask_next = mask;
    total_next = total; emitted_next = emitted; sasm_next = sasm; bis_next = bis;
    emit = 1'b0; need_div = 1'b0; do_take = 1'b0; do_finish = 1'b0;
    e_kind = wavp_pkg::KIND_ERR; e_status = wavp_pkg::ST_OK; e_value = '0;

    if (stream_end) begin
      case (phase)
        wavp_pkg::PH_MAGIC: e_status = (fbi == 6'd0 && raw_mode) ?
                                       wavp_pkg::ST_OK : wavp_pkg::ST_BAD_HDR;
        wavp_pkg::PH_HDR_FMT, wavp_pkg::PH_SKIP_FMT: e_status = wavp_pkg::ST_BAD_HDR;
        wavp_pkg::PH_FMT_BODY: e_status = wavp_pkg::ST_FMT_SIZE;
        wavp_pkg::PH_HDR_DATA, wavp_pkg::PH_SKIP_DATA: e_status = wavp_pkg::ST_NO_DATA;
        default: e_status = wavp_pkg::ST_OK;
      endcase
      emit = (e_status != wavp_pkg::ST_OK);
      phase_next = wavp_pkg::PH_MAGIC;
      fbi_next = '0; chunk_next = '0; word_next = '0; fmt_size_next = '0;
      fmt_code_next = '0; sub_fmt_next = '0; ch_next = '0; rate_next = '0;
      sbytes_next = '0; mask_next = '0; total_next = '0; emitted_next = '0;
      sasm_next = '0; bis_next = '0;
    end else begin
      case (phase)
        wavp_pkg::PH_MAGIC: begin
          if (fbi == 6'd0 && raw_mode) begin
            phase_next  = wavp_pkg::PH_SAMPLES;
            sbytes_next = {11'b0, raw_sample_bytes};
            total_next  = wavp_pkg::RAW_LIMIT;
            do_take     = 1'b1;
          end else begin
            word_next = {data_byte, word[31:8]};
            if ((fbi == 6'd3 && word_next != wavp_pkg::ID_RIFF) ||
                (fbi == 6'd11 && word_next != wavp_pkg::ID_WAVE)) begin
              emit = 1'b1; e_status = wavp_pkg::ST_BAD_HDR;
            end else begin
              fbi_next = fbi + 6'd1;
              if (fbi_next >= 6'd12) begin
                phase_next = wavp_pkg::PH_HDR_FMT;
                fbi_next   = '0;
              end
            end
          end
        end
        wavp_pkg::PH_HDR_FMT, wavp_pkg::PH_HDR_DATA: begin
          if (fbi < 6'd4) word_next = {data_byte, word[31:8]};
          else chunk_next = {data_byte, chunk[31:8]};
          fbi_next = fbi + 6'd1;
          if (fbi_next >= 6'd8) begin
            fbi_next = '0;
            if (phase == wavp_pkg::PH_HDR_FMT && word_next == wavp_pkg::ID_FMT) begin
              if (chunk_next > {26'b0, wavp_pkg::FMT_MAX}) begin
                emit = 1'b1; e_status = wavp_pkg::ST_FMT_SIZE;
              end else begin
                fmt_size_next = chunk_next[5:0];
                word_next     = '0;
                phase_next    = wavp_pkg::PH_FMT_BODY;
                do_finish     = (chunk_next[5:0] == 6'd0);
              end
            end else if (phase == wavp_pkg::PH_HDR_DATA && word_next == wavp_pkg::ID_DATA) begin
              phase_next = wavp_pkg::PH_SAMPLES;
              need_div   = 1'b1;
            end else if (chunk_next != 32'd0) begin
              phase_next = (phase == wavp_pkg::PH_HDR_FMT) ?
                           wavp_pkg::PH_SKIP_FMT : wavp_pkg::PH_SKIP_DATA;
            end
          end
        end
        wavp_pkg::PH_SKIP_FMT, wavp_pkg::PH_SKIP_DATA: begin
          chunk_next = chunk - 32'd1;
          if (chunk_next == 32'd0) begin
            phase_next = (phase == wavp_pkg::PH_SKIP_FMT) ?
                         wavp_pkg::PH_HDR_FMT : wavp_pkg::PH_HDR_DATA;
          end
        end
        wavp_pkg::PH_FMT_BODY: begin
          case (fbi) inside
            [6'd0:6'd1]:   fmt_code_next = {data_byte, fmt_code[15:8]};
            [6'd2:6'd3]:   ch_next       = {data_byte, ch[15:8]};
            [6'd4:6'd7]:   rate_next     = {data_byte, rate[31:8]};
            [6'd14:6'd15]: word_next     = {16'b0, data_byte, word[15:8]};
            [6'd20:6'd23]: mask_next     = {data_byte, mask[31:8]};
            [6'd24:6'd25]: sub_fmt_next  = {data_byte, sub_fmt[15:8]};
            default: ;
          endcase
          fbi_next  = fbi + 6'd1;
          do_finish = (fbi_next >= fmt_size);
        end
        wavp_pkg::PH_SAMPLES: do_take = 1'b1;
        default: ;
      endcase

      // judge a complete fmt chunk
      if (do_finish) begin
        sbytes_next = bits_sum[16:3];
        if (fmt_code_next != wavp_pkg::FMT_PCM &&
            (fmt_code_next != wavp_pkg::FMT_EXT || sub_fmt_next != wavp_pkg::FMT_PCM)) begin
          emit = 1'b1; e_status = wavp_pkg::ST_NOT_PCM;
        end else if (ch_next == 16'd0) begin
          emit = 1'b1; e_status = wavp_pkg::ST_NO_CH;
        end else if (bits_sum[16:3] == 14'd0) begin
          emit = 1'b1; e_status = wavp_pkg::ST_NO_SIZE;
        end else begin
          if (fmt_size_next != wavp_pkg::FMT_MAX) mask_next = '0;
          phase_next = wavp_pkg::PH_HDR_DATA;
          fbi_next   = '0;
        end
      end
      if (emit) phase_next = wavp_pkg::PH_HALT;

      // sample unpacking
      if (do_take && sbytes_next >= 14'd2 && sbytes_next <= 14'd4 &&
          emitted < total_next) begin
        case (bis)
          2'd0: sasm_next = sasm | {24'b0, data_byte};
          2'd1: sasm_next = sasm | {16'b0, data_byte, 8'b0};
          2'd2: sasm_next = sasm | {8'b0, data_byte, 16'b0};
          default: sasm_next = sasm | {data_byte, 24'b0};
        endcase
        if ({12'b0, bis} + 14'd1 < sbytes_next) begin
          bis_next = bis + 2'd1;
        end else begin
          case (sbytes_next[2:0])
            3'd2: e_value = {sasm_next[15:0], 16'b0};
            3'd3: e_value = {sasm_next[23:0], 8'b0};
            default: e_value = sasm_next;
          endcase
          sasm_next    = '0;
          bis_next     = '0;
          emitted_next = emitted + 32'd1;
          emit         = 1'b1;
          e_kind       = wavp_pkg::KIND_SMP;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode         <= 1'b0;
      raw_sample_bytes <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        wavp_pkg::REG_RAW_MODE:  raw_mode <= cfg_data[0];
        wavp_pkg::REG_RAW_BYTES: raw_sample_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavp_pkg::PH_MAGIC;
      fbi <= '0; chunk <= '0; word <= '0; fmt_size <= '0; fmt_code <= '0;
      sub_fmt <= '0; ch <= '0; rate <= '0; sbytes <= '0; mask <= '0;
      total <= '0; emitted <= '0; sasm <= '0; bis <= '0;
    end else if (cmd.step) begin
      phase <= phase_next; fbi <= fbi_next; chunk <= chunk_next; word <= word_next;
      fmt_size <= fmt_size_next; fmt_code <= fmt_code_next; sub_fmt <= sub_fmt_next;
      ch <= ch_next; rate <= rate_next; sbytes <= sbytes_next; mask <= mask_next;
      total <= total_next; emitted <= emitted_next; sasm <= sasm_next; bis <= bis_next;
    end else if (cmd.store_total) begin
      total <= quot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_step) begin
      kind <= e_kind; status <= e_status; sample_value <= e_value;
      channels <= '0; sample_rate <= '0; bytes_per_sample <= '0;
      channel_mask <= '0; sample_count <= '0; frame_count <= '0;
    end else if (cmd.load_hdr) begin
      kind <= wavp_pkg::KIND_HDR; status <= wavp_pkg::ST_OK; sample_value <= '0;
      channels <= ch; sample_rate <= rate; bytes_per_sample <= sbytes;
      channel_mask <= mask; sample_count <= total; frame_count <= quot;
    end
  end
endmodule
`default_nettype wire

// File: hdl/wavp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wavp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire wavp_pkg::dp_sts_t sts,
  output wavp_pkg::dp_cmd_t      cmd
);
  wavp_pkg::ctrl_state_t state, state_next;
  logic slot_free, accept, load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == wavp_pkg::CS_RUN) && slot_free;
  assign accept    = in_valid && in_ready;
  assign load      = cmd.load_step || cmd.load_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wavp_pkg::CS_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // byte steps, and the header path: two divisions, then the header request
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      wavp_pkg::CS_RUN: begin
        cmd.step      = accept;
        cmd.load_step = accept && sts.res_valid;
        if (accept && sts.need_div) state_next = wavp_pkg::CS_SAMP_GO;
      end
      wavp_pkg::CS_SAMP_GO: begin
        cmd.div_start = 1'b1;
        state_next    = wavp_pkg::CS_SAMP_WAIT;
      end
      wavp_pkg::CS_SAMP_WAIT: begin
        if (!sts.div_busy) begin
          cmd.store_total = 1'b1;
          state_next      = wavp_pkg::CS_FRM_GO;
        end
      end
      wavp_pkg::CS_FRM_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_frames = 1'b1;
        state_next     = wavp_pkg::CS_FRM_WAIT;
      end
      wavp_pkg::CS_FRM_WAIT: begin
        cmd.div_frames = 1'b1;
        if (!sts.div_busy) state_next = wavp_pkg::CS_HDR;
      end
      wavp_pkg::CS_HDR: begin
        cmd.div_frames = 1'b1;
        if (slot_free) begin
          cmd.load_hdr = 1'b1;
          state_next   = wavp_pkg::CS_RUN;
        end
      end
      default: state_next = wavp_pkg::CS_RUN;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/wavp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wav_header_parse_and_unpack_defines.svh"
module wavp_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic [2:0] status
);
  // a pending result is not dropped
  `WAVP_NEXT(a_hold, out_valid && !out_ready, out_valid)
  `WAVP_IMPLY(a_kind, out_valid, kind != wavp_pkg::KIND_ERR + 2'd1)
  `WAVP_IMPLY(a_smp_ok, out_valid && kind == wavp_pkg::KIND_SMP, status == wavp_pkg::ST_OK)
  `WAVP_IMPLY(a_err_code, out_valid && kind == wavp_pkg::KIND_ERR, status != wavp_pkg::ST_OK)
endmodule

bind wav_header_parse_and_unpack wavp_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .kind      (res.kind),
  .status    (res.status)
);
`default_nettype wire
